@@ hw/rtl/mmpq_pkg.sv @@
`timescale 1ns / 1ps

package mmpq_pkg;

    // Pool and queue sizing
    localparam int NUM_QUEUES = 16;
    localparam int CAPACITY   = 64;

    localparam int QW   = $clog2(NUM_QUEUES);     // queue number width
    localparam int IW   = $clog2(CAPACITY);       // entry index width
    localparam int SCW  = $clog2(CAPACITY + 1);   // scan counter, holds CAPACITY
    localparam int CNTW = 7;                      // count field width

    localparam int OPW  = 2;
    localparam int QFW  = 4;                      // queue field width on the port
    localparam int JOBW = 20;
    localparam int PRIW = 16;
    localparam int STW  = 2;

    // Operation codes
    typedef enum logic [OPW-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_MERGE  = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    // Result status codes
    localparam logic [STW-1:0] ST_OK    = 2'd0;
    localparam logic [STW-1:0] ST_EMPTY = 2'd1;
    localparam logic [STW-1:0] ST_FULL  = 2'd2;

    // Input transaction
    typedef struct packed {
        logic [OPW-1:0]  opcode;
        logic [QFW-1:0]  queue_a;
        logic [QFW-1:0]  queue_b;
        logic [JOBW-1:0] job_id;
        logic [PRIW-1:0] priority_req;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [STW-1:0]  status;
        logic [JOBW-1:0] job_out;
        logic [CNTW-1:0] count;
    } out_item_t;

    // One pool entry as stored in the entry memory
    typedef struct packed {
        logic [QW-1:0]   queue;
        logic [PRIW-1:0] prio;
        logic [JOBW-1:0] job;
    } entry_t;

    // Candidate offered to the compare unit
    typedef struct packed {
        logic            en;
        logic [IW-1:0]   idx;
        logic [PRIW-1:0] prio;
        logic [JOBW-1:0] job;
    } cand_t;

    // Running winner held by the compare unit
    typedef struct packed {
        logic            found;
        logic [IW-1:0]   idx;
        logic [JOBW-1:0] job;
    } best_t;

endpackage

@@ hw/rtl/mmpq_ram.sv @@
`timescale 1ns / 1ps

module mmpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/mmpq_best.sv @@
`timescale 1ns / 1ps

module mmpq_best (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           clear,
    input  mmpq_pkg::cand_t cand,
    output mmpq_pkg::best_t best
);

    import mmpq_pkg::*;

    logic            found_reg, found_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [PRIW-1:0] prio_reg, prio_next;
    logic [JOBW-1:0] job_reg, job_next;
    logic            take;

    // Shared comparator: strict greater keeps the lowest index on ties
    assign take = cand.en && (!found_reg || (cand.prio > prio_reg));

    always_comb begin
        found_next = found_reg;
        idx_next   = idx_reg;
        prio_next  = prio_reg;
        job_next   = job_reg;
        if (clear) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next = 1'b1;
            idx_next   = cand.idx;
            prio_next  = cand.prio;
            job_next   = cand.job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        idx_reg  <= idx_next;
        prio_reg <= prio_next;
        job_reg  <= job_next;
    end

    assign best.found = found_reg;
    assign best.idx   = idx_reg;
    assign best.job   = job_reg;

endmodule

@@ hw/rtl/mergeable_multi_priority_queue.sv @@
`timescale 1ns / 1ps

// Keeps NUM_QUEUES priority queues in one pool of CAPACITY entries. Each
// transaction yields one result. Insert, pop and a merge of two different
// queues walk the whole pool one entry per cycle through the entry memory's
// read port; insert and pop pick their entry with a single priority
// comparator. A merge of a queue into itself and a no-op skip the walk.
// s_ready is high only between transactions; a finished result waits in the
// output register while the next transaction is accepted.
module mergeable_multi_priority_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mmpq_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output mmpq_pkg::out_item_t m_payload
);

    import mmpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOADA,
        S_LOADB,
        S_SCAN,
        S_COMMIT,
        S_COMMIT2,
        S_RESP
    } state_t;

    localparam logic [SCW-1:0] SCAN_END = SCW'(CAPACITY);

    state_t              state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [QW-1:0]       qa_reg, qa_next;
    logic [QW-1:0]       qb_reg, qb_next;
    logic [JOBW-1:0]     job_reg, job_next;
    logic [PRIW-1:0]     pri_reg, pri_next;
    logic [CNTW-1:0]     cnt_a_reg, cnt_a_next;
    logic [CNTW-1:0]     cnt_b_reg, cnt_b_next;
    logic [SCW-1:0]      idx_reg, idx_next;
    logic                proc_en_reg, proc_en_next;
    logic [IW-1:0]       proc_idx_reg, proc_idx_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [NUM_QUEUES-1:0] cvalid_reg, cvalid_next;
    out_item_t           res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_payload_reg, m_payload_next;

    // Memory ports
    logic                ent_we;
    logic [IW-1:0]       ent_waddr;
    entry_t              ent_wdata;
    logic [IW-1:0]       ent_raddr;
    entry_t              ent_rdata;
    logic                cnt_we;
    logic [QW-1:0]       cnt_waddr;
    logic [CNTW-1:0]     cnt_wdata;
    logic [QW-1:0]       cnt_raddr;
    logic [CNTW-1:0]     cnt_rdata;

    // Compare unit
    logic                best_clear;
    cand_t               cand;
    best_t               best;

    logic                accept;
    logic                hit;
    logic [CNTW-1:0]     cnt_dec;

    mmpq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(CAPACITY)
    ) u_entry_ram (
        .aclk (aclk),
        .we   (ent_we),
        .waddr(ent_waddr),
        .wdata(ent_wdata),
        .raddr(ent_raddr),
        .rdata(ent_rdata)
    );

    mmpq_ram #(
        .WIDTH(CNTW),
        .DEPTH(NUM_QUEUES)
    ) u_count_ram (
        .aclk (aclk),
        .we   (cnt_we),
        .waddr(cnt_waddr),
        .wdata(cnt_wdata),
        .raddr(cnt_raddr),
        .rdata(cnt_rdata)
    );

    mmpq_best u_best (
        .aclk   (aclk),
        .aresetn(aresetn),
        .clear  (best_clear),
        .cand   (cand),
        .best   (best)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Entry in the compare stage belongs to the source queue
    assign hit = proc_en_reg && valid_reg[proc_idx_reg] && (ent_rdata.queue == qa_reg);

    assign cnt_dec = (cnt_a_reg != '0) ? (cnt_a_reg - CNTW'(1)) : '0;

    // Read addresses
    assign ent_raddr = idx_reg[IW-1:0];
    assign cnt_raddr = (state_reg == S_IDLE) ? s_payload.queue_a[QW-1:0] : qb_reg;

    // Candidate for the comparator: first free slot on insert, best match on pop
    always_comb begin
        cand.idx  = proc_idx_reg;
        cand.job  = ent_rdata.job;
        cand.prio = ent_rdata.prio;
        cand.en   = 1'b0;
        if (state_reg == S_SCAN) begin
            case (op_reg)
                OP_INSERT: begin
                    cand.en   = proc_en_reg && !valid_reg[proc_idx_reg];
                    cand.prio = '0;
                end
                OP_POP: begin
                    cand.en = hit;
                end
                default: begin
                    cand.en = 1'b0;
                end
            endcase
        end
    end

    assign best_clear = (state_reg == S_LOADB);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        job_next       = job_reg;
        pri_next       = pri_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        idx_next       = idx_reg;
        proc_en_next   = 1'b0;
        proc_idx_next  = proc_idx_reg;
        valid_next     = valid_reg;
        cvalid_next    = cvalid_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;

        ent_we    = 1'b0;
        ent_waddr = proc_idx_reg;
        ent_wdata = '{queue: qb_reg, prio: ent_rdata.prio, job: ent_rdata.job};
        cnt_we    = 1'b0;
        cnt_waddr = qa_reg;
        cnt_wdata = '0;

        // Output register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next    = opcode_t'(s_payload.opcode);
                    qa_next    = s_payload.queue_a[QW-1:0];
                    qb_next    = s_payload.queue_b[QW-1:0];
                    job_next   = s_payload.job_id;
                    pri_next   = s_payload.priority_req;
                    state_next = S_LOADA;
                end
            end
            S_LOADA: begin
                cnt_a_next = cvalid_reg[qa_reg] ? cnt_rdata : '0;
                state_next = S_LOADB;
            end
            S_LOADB: begin
                cnt_b_next = cvalid_reg[qb_reg] ? cnt_rdata : '0;
                idx_next   = '0;
                if (op_reg == OP_NOP) begin
                    res_next   = '{status: ST_OK, job_out: '0, count: '0};
                    state_next = S_RESP;
                end else if ((op_reg == OP_MERGE) && (qa_reg == qb_reg)) begin
                    state_next = S_COMMIT;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue read of idx, process the entry whose read was issued in the previous cycle
                proc_en_next  = (idx_reg != SCAN_END);
                proc_idx_next = idx_reg[IW-1:0];
                idx_next      = idx_reg + SCW'(1);
                if ((op_reg == OP_MERGE) && hit) begin
                    ent_we = 1'b1;
                end
                if (idx_reg == SCAN_END) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                state_next = S_RESP;
                case (op_reg)
                    OP_INSERT: begin
                        if (best.found) begin
                            ent_we     = 1'b1;
                            ent_waddr  = best.idx;
                            ent_wdata  = '{queue: qa_reg, prio: pri_reg, job: job_reg};
                            valid_next[best.idx] = 1'b1;
                            cnt_we     = 1'b1;
                            cnt_waddr  = qa_reg;
                            cnt_wdata  = cnt_a_reg + CNTW'(1);
                            cvalid_next[qa_reg] = 1'b1;
                            res_next   = '{status: ST_OK, job_out: '0,
                                           count: cnt_a_reg + CNTW'(1)};
                        end else begin
                            res_next   = '{status: ST_FULL, job_out: '0, count: cnt_a_reg};
                        end
                    end
                    OP_POP: begin
                        if (best.found) begin
                            valid_next[best.idx] = 1'b0;
                            cnt_we     = 1'b1;
                            cnt_waddr  = qa_reg;
                            cnt_wdata  = cnt_dec;
                            cvalid_next[qa_reg] = 1'b1;
                            res_next   = '{status: ST_OK, job_out: best.job, count: cnt_dec};
                        end else begin
                            res_next   = '{status: ST_EMPTY, job_out: '0, count: '0};
                        end
                    end
                    OP_MERGE: begin
                        if (qa_reg != qb_reg) begin
                            cnt_we     = 1'b1;
                            cnt_waddr  = qb_reg;
                            cnt_wdata  = cnt_a_reg + cnt_b_reg;
                            cvalid_next[qb_reg] = 1'b1;
                            res_next   = '{status: ST_OK, job_out: '0,
                                           count: cnt_a_reg + cnt_b_reg};
                            state_next = S_COMMIT2;
                        end else begin
                            res_next   = '{status: ST_OK, job_out: '0, count: cnt_b_reg};
                        end
                    end
                    default: begin
                        res_next = '{status: ST_OK, job_out: '0, count: '0};
                    end
                endcase
            end
            S_COMMIT2: begin
                // Source queue of a merge is now empty
                cnt_we     = 1'b1;
                cnt_waddr  = qa_reg;
                cnt_wdata  = '0;
                cvalid_next[qa_reg] = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            proc_en_reg <= 1'b0;
            valid_reg   <= '0;
            cvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            proc_en_reg <= proc_en_next;
            valid_reg   <= valid_next;
            cvalid_reg  <= cvalid_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg        <= op_next;
        qa_reg        <= qa_next;
        qb_reg        <= qb_next;
        job_reg       <= job_next;
        pri_reg       <= pri_next;
        cnt_a_reg     <= cnt_a_next;
        cnt_b_reg     <= cnt_b_next;
        idx_reg       <= idx_next;
        proc_idx_reg  <= proc_idx_next;
        res_reg       <= res_next;
        m_payload_reg <= m_payload_next;
    end

endmodule

@@ hw/rtl/mmpq_checker.sv @@
`timescale 1ns / 1ps

module mmpq_assertions (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input mmpq_pkg::out_item_t m_payload
);

    import mmpq_pkg::*;

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // One transaction at a time: ready drops right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // Empty pop reports no job and zero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status == ST_EMPTY) |->
            (m_payload.job_out == '0) && (m_payload.count == '0))
        else $error("empty pop with job or count");

    // Counts never exceed the pool size, and only results with status OK carry a job
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.count <= CNTW'(CAPACITY)) &&
            ((m_payload.status == ST_OK) || (m_payload.job_out == '0)))
        else $error("bad count or job in result");

endmodule

bind mergeable_multi_priority_queue mmpq_assertions u_mmpq_assertions (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_payload(m_payload)
);
